### hdl/sorted_array_priority_queue_top_assert.svh
// Assertion macros for the priority queue.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Checked while out of reset.
`define SAPRQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SAPRQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/saprq_pkg.sv
package saprq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned OCC_W      = 5;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - VAL_W - OCC_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_e;

  // Broadcast to every cell.
  typedef struct packed {
    logic             load;
    logic             insert;
    logic [VAL_W-1:0] value;
  } cmd_t;

  // Handed from a cell to its neighbours.
  typedef struct packed {
    logic             keep;
    logic [VAL_W-1:0] value;
  } link_t;

endpackage

### hdl/sorted_array_priority_queue_top.sv
// Channel  Dir  tdata                                   tuser
// s_axis   in   [31:0] value                            [0] mode
// m_axis   out  [31:0] removed_value, [36:32] occupancy [1:0] status
//
// One word per cycle is taken while s_axis_tready is high; its result appears
// in the output register on the next cycle. The compare-and-shift across the
// cell row is combinational. Reset clears the fill count and the output valid;
// cell contents are left as they are.
// s_axis_tready is low only while a result waits and m_axis_tready is low.
`include "sorted_array_priority_queue_top_assert.svh"

module sorted_array_priority_queue_top
  import saprq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VAL_W-1:0]      s_axis_tdata,   // [31:0] value
  input  logic                  s_axis_tuser,   // [0] mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] removed_value, [36:32] occupancy
  output logic [STATUS_W-1:0]   m_axis_tuser    // [1:0] status
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  logic [VAL_W-1:0] removed_q, removed_d;
  logic [OCC_W-1:0] occ_q;

  logic  accept, full, empty, is_insert;
  cmd_t  cmd;
  link_t links [DEPTH];
  link_t front;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_insert     = (s_axis_tuser == MODE_INSERT);
  assign full          = (cnt_q == CNT_W'(DEPTH));
  assign empty         = (cnt_q == '0);

  assign cmd.load   = accept && (is_insert ? !full : !empty);
  assign cmd.insert = is_insert;
  assign cmd.value  = s_axis_tdata;

  assign front.keep  = 1'b1;
  assign front.value = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    link_t            prev;
    logic [VAL_W-1:0] next_value;
    if (i == 0) begin : g_first
      assign prev = front;
    end else begin : g_mid
      assign prev = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_value = links[i].value;
    end else begin : g_inner
      assign next_value = links[i+1].value;
    end
    saprq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occupied_i   (CNT_W'(i) < cnt_q),
      .prev_i       (prev),
      .next_value_i (next_value),
      .link_o       (links[i])
    );
  end

  always_comb begin
    cnt_d     = cnt_q;
    status_d  = ST_OK;
    removed_d = '0;
    if (is_insert) begin
      if (full) begin
        status_d = ST_OVERFLOW;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_d = ST_UNDERFLOW;
      end else begin
        cnt_d     = cnt_q - CNT_W'(1);
        removed_d = links[0].value;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      occ_q     <= OCC_W'(cnt_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, occ_q, removed_q};
  assign m_axis_tuser  = status_q;

  `SAPRQ_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "fill count beyond depth")
  `SAPRQ_ASSERT(a_result_follows, accept |=> m_axis_tvalid, "accepted word gave no result")
  `SAPRQ_ASSERT(a_overflow,
      accept && is_insert && full |=> status_q == ST_OVERFLOW && $stable(cnt_q),
      "full insert not refused")
  `SAPRQ_ASSERT(a_remove_dec,
      accept && !is_insert && !empty |=> cnt_q == $past(cnt_q) - CNT_W'(1),
      "remove did not shrink count")
  `SAPRQ_ASSERT(a_front_order,
      cnt_q >= CNT_W'(2) |-> $signed(links[0].value) >= $signed(links[1].value),
      "front cells out of order")

endmodule

### hdl/saprq_cell.sv
module saprq_cell
  import saprq_pkg::*;
(
  input  logic             clk_i,
  input  cmd_t             cmd_i,
  input  logic             occupied_i,
  input  link_t            prev_i,
  input  logic [VAL_W-1:0] next_value_i,
  output link_t            link_o
);

  logic [VAL_W-1:0] value_q, value_d;
  logic             keep;

  // On insert, an occupied cell's stored value stays put when it is >= the new one (signed).
  assign keep = occupied_i && !($signed(cmd_i.value) > $signed(value_q));

  always_comb begin
    value_d = value_q;
    if (cmd_i.load) begin
      if (cmd_i.insert) begin
        if (!keep) begin
          value_d = prev_i.keep ? cmd_i.value : prev_i.value;
        end
      end else begin
        value_d = next_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.keep  = keep;
  assign link_o.value = value_q;

endmodule
